@@ rtl/wbps_pkg.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern search - shared package
// Widths, defaults, register indexes and the result record.
// ---------------------------------------------------------------------------
package wbps_pkg;

    // Parameter defaults
    localparam int MAX_PATTERN_DEF  = 16;
    localparam int OFFSET_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int PAT_W    = 64;
    localparam int MASK_W   = 16;
    localparam int LEN_W    = 5;
    localparam int RES_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Result queue depth and pointer width
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_WILD     = 2'd2,
        REG_LEN      = 2'd3
    } t_cfg_reg;

    // One result item
    typedef struct packed {
        logic [RES_W-1:0] match_offset;
        logic             is_summary;
        logic [RES_W-1:0] match_total;
        logic             unique_match;
        logic             last_result;
    } t_result;

endpackage

@@ rtl/wbps_in_if.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern search - input byte channel
// Valid/ready channel carrying one stream byte and its end marker.
// ---------------------------------------------------------------------------
interface wbps_in_if
    import wbps_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

@@ rtl/wbps_out_if.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern search - result channel
// Valid/ready channel carrying match reports and stream summaries.
// ---------------------------------------------------------------------------
interface wbps_out_if
    import wbps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] match_offset;
    logic             is_summary;
    logic [RES_W-1:0] match_total;
    logic             unique_match;
    logic             last_result;

    modport source (output valid, output match_offset, output is_summary,
                    output match_total, output unique_match, output last_result,
                    input ready);
    modport sink   (input valid, input match_offset, input is_summary,
                    input match_total, input unique_match, input last_result,
                    output ready);
endinterface

@@ rtl/wbps_res_queue.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern search - result queue
// Small queue taking up to two results per cycle and giving one per cycle while the sink is ready.
// ---------------------------------------------------------------------------
module wbps_res_queue
    import wbps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,   // 0, 1 or 2 entries
    input  t_result           i_ent0,
    input  t_result           i_ent1,
    output logic              o_room2,      // at least two free slots
    wbps_out_if.source        o_res
);

    t_result               r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wp;
    logic [RQ_PTR_W-1:0]   r_rp;
    logic [RQ_CNT_W-1:0]   r_cnt;
    logic                  w_pop;
    t_result               w_head;

    assign w_pop   = o_res.valid && o_res.ready;
    assign o_room2 = (r_cnt <= RQ_CNT_W'(RQ_DEPTH - 2));

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RQ_PTR_W'(i_push_cnt);
            r_rp  <= r_rp + RQ_PTR_W'(w_pop);
            r_cnt <= r_cnt + RQ_CNT_W'(i_push_cnt) - RQ_CNT_W'(w_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_ent0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + RQ_PTR_W'(1)] <= i_ent1;
        end
    end

    // Head of queue drives the channel
    assign w_head             = r_mem[r_rp];
    assign o_res.valid        = (r_cnt != '0);
    assign o_res.match_offset = w_head.match_offset;
    assign o_res.is_summary   = w_head.is_summary;
    assign o_res.match_total  = w_head.match_total;
    assign o_res.unique_match = w_head.unique_match;
    assign o_res.last_result  = w_head.last_result;

endmodule

@@ rtl/wildcard_byte_pattern_search.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern search - top level
// Scans a byte stream for a pattern with wildcard positions, reports each
// match start offset and a summary at the end of every stream.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                         per transfer
//  i_in     in   data_byte, stream_end                           one byte
//  o_res    out  match_offset, is_summary, match_total,          one result
//                unique_match, last_result
//  i_cfg_*  in   index, data (write only)                        one register
//
//  One byte per cycle while the queue has room; the window compare sits
//  between the byte window register and the result queue. A byte gives up
//  to two results, queued as it is transferred. Input is taken while the
//  four-entry queue has two free slots, so a stalled sink backs up input
//  once three or more results wait; bytes giving no result never fill it.
//  Sync reset clears window, counters and queue; config takes its defaults.
// ---------------------------------------------------------------------------
module wildcard_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data,
    wbps_in_if.sink              i_in,
    wbps_out_if.source           o_res
);

    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers
    logic [PAT_W-1:0]  r_pat_low;
    logic [PAT_W-1:0]  r_pat_high;
    logic [MASK_W-1:0] r_wild;
    logic [LEN_W-1:0]  r_len;

    // Stream state
    logic [BYTE_W-1:0]       r_win [MAX_PATTERN];
    logic [FILL_W-1:0]       r_fill;
    logic [OFFSET_WIDTH-1:0] r_seen;
    logic [RES_W-1:0]        r_count;

    logic [BYTE_W-1:0]       n_win [MAX_PATTERN];
    logic [FILL_W-1:0]       n_fill;
    logic [RES_W-1:0]        n_count;
    logic [2*PAT_W-1:0]      w_pat;
    logic [LEN_W-1:0]        w_len;
    logic [LEN_W-1:0]        w_k;
    logic                    w_hit;
    logic                    w_acc;
    logic                    w_room2;
    logic [OFFSET_WIDTH-1:0] w_start;
    logic [1:0]              w_push_cnt;
    t_result                 w_match_res;
    t_result                 w_sum_res;
    t_result                 w_ent0;

    assign i_in.ready = w_room2;
    assign w_acc      = i_in.valid && w_room2;
    assign w_pat      = {r_pat_high, r_pat_low};

    // Config write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_wild     <= '0;
            r_len      <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                REG_PAT_HIGH: r_pat_high <= i_cfg_data;
                REG_WILD:     r_wild     <= i_cfg_data[MASK_W-1:0];
                REG_LEN:      r_len      <= i_cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective length: zero acts as one, clamp to window depth
    always_comb begin
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = r_len;
        end
    end

    // Window with the incoming byte shifted in, newest at index 0
    always_comb begin
        n_win[0] = i_in.data_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_fill = (r_fill == FILL_W'(MAX_PATTERN)) ? r_fill : r_fill + FILL_W'(1);
    end

    // Parallel compare: pattern position i against window byte len-1-i
    always_comb begin
        w_hit = (LEN_W'(n_fill) >= w_len);
        w_k   = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_k = w_len - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < w_len) && !r_wild[i]
                && (n_win[w_k[IDX_W-1:0]] != w_pat[8*i +: 8])) begin
                w_hit = 1'b0;
            end
        end
    end

    // Match start offset and saturating count
    assign w_start = r_seen + OFFSET_WIDTH'(1) - OFFSET_WIDTH'(w_len);
    assign n_count = (w_hit && (r_count != '1)) ? r_count + RES_W'(1) : r_count;

    // Result records
    always_comb begin
        w_match_res.match_offset = RES_W'(w_start);
        w_match_res.is_summary   = 1'b0;
        w_match_res.match_total  = n_count;
        w_match_res.unique_match = 1'b0;
        w_match_res.last_result  = !i_in.stream_end;

        w_sum_res.match_offset   = '0;
        w_sum_res.is_summary     = 1'b1;
        w_sum_res.match_total    = n_count;
        w_sum_res.unique_match   = (n_count == RES_W'(1));
        w_sum_res.last_result    = 1'b1;

        w_ent0     = w_hit ? w_match_res : w_sum_res;
        w_push_cnt = w_acc ? (2'(w_hit) + 2'(i_in.stream_end)) : 2'd0;
    end

    // Stream state update; stream end clears window, fill, offset and match count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_seen  <= '0;
            r_count <= '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= '0;
            end
        end else if (w_acc) begin
            if (i_in.stream_end) begin
                r_fill  <= '0;
                r_seen  <= '0;
                r_count <= '0;
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    r_win[j] <= '0;
                end
            end else begin
                r_fill  <= n_fill;
                r_seen  <= r_seen + OFFSET_WIDTH'(1);
                r_count <= n_count;
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    r_win[j] <= n_win[j];
                end
            end
        end
    end

    // Result queue
    wbps_res_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_ent0     (w_ent0),
        .i_ent1     (w_sum_res),
        .o_room2    (w_room2),
        .o_res      (o_res)
    );

endmodule
